[hdl/ldbc_pkg.sv]
// shared types, codes and reset values of the ladder button click decoder
`default_nettype none

package ldbc_pkg;

  // widths fixed by the register and result fields
  localparam int unsigned THR_W   = 10;
  localparam int unsigned TICKS_W = 8;
  localparam int unsigned CLASS_W = 3;
  localparam int unsigned EVENT_W = 3;
  localparam int unsigned CLICK_W = 4;
  localparam int unsigned INDEX_W = 3;

  // parameter defaults
  localparam int unsigned HISTORY_LEN_DEF = 30;
  localparam int unsigned QUIET_LEN_DEF   = 4;
  localparam int unsigned SAMPLE_BITS_DEF = 10;

  // key classes
  localparam logic [CLASS_W-1:0] KEY_OPEN   = 3'd0;
  localparam logic [CLASS_W-1:0] KEY_CENTER = 3'd1;
  localparam logic [CLASS_W-1:0] KEY_D      = 3'd2;
  localparam logic [CLASS_W-1:0] KEY_PLUS   = 3'd3;
  localparam logic [CLASS_W-1:0] KEY_MINUS  = 3'd4;

  // event codes
  localparam logic [EVENT_W-1:0] EV_NONE      = 3'd0;
  localparam logic [EVENT_W-1:0] EV_CLICKS    = 3'd1;
  localparam logic [EVENT_W-1:0] EV_PRESS_UP  = 3'd2;
  localparam logic [EVENT_W-1:0] EV_PRESS_DN  = 3'd3;
  localparam logic [EVENT_W-1:0] EV_LONG_UP   = 3'd4;
  localparam logic [EVENT_W-1:0] EV_LONG_DN   = 3'd5;

  // register indexes
  localparam logic [INDEX_W-1:0] REG_CENTER_BELOW = 3'd0;
  localparam logic [INDEX_W-1:0] REG_D_FROM       = 3'd1;
  localparam logic [INDEX_W-1:0] REG_D_BELOW      = 3'd2;
  localparam logic [INDEX_W-1:0] REG_PLUS_FROM    = 3'd3;
  localparam logic [INDEX_W-1:0] REG_PLUS_BELOW   = 3'd4;
  localparam logic [INDEX_W-1:0] REG_MINUS_FROM   = 3'd5;
  localparam logic [INDEX_W-1:0] REG_MINUS_BELOW  = 3'd6;
  localparam logic [INDEX_W-1:0] REG_LONG_TICKS   = 3'd7;

  // register reset values
  localparam logic [THR_W-1:0]   RST_CENTER_BELOW = 10'd31;
  localparam logic [THR_W-1:0]   RST_D_FROM       = 10'd44;
  localparam logic [THR_W-1:0]   RST_D_BELOW      = 10'd73;
  localparam logic [THR_W-1:0]   RST_PLUS_FROM    = 10'd74;
  localparam logic [THR_W-1:0]   RST_PLUS_BELOW   = 10'd124;
  localparam logic [THR_W-1:0]   RST_MINUS_FROM   = 10'd134;
  localparam logic [THR_W-1:0]   RST_MINUS_BELOW  = 10'd224;
  localparam logic [TICKS_W-1:0] RST_LONG_TICKS   = 8'd10;

  localparam logic [TICKS_W-1:0] HOLD_MAX  = 8'd255;
  localparam logic [CLICK_W-1:0] CLICK_MAX = 4'd15;

  // band thresholds handed to the classifier
  typedef struct packed {
    logic [THR_W-1:0] center_below;
    logic [THR_W-1:0] d_from;
    logic [THR_W-1:0] d_below;
    logic [THR_W-1:0] plus_from;
    logic [THR_W-1:0] plus_below;
    logic [THR_W-1:0] minus_from;
    logic [THR_W-1:0] minus_below;
  } bands_t;

endpackage

`default_nettype wire

[hdl/ladder_button_click_decoder.sv]
// top level: headset ladder button decoder with click counting and long press
//
// One beat on the input channel carries one converter reading of the ladder
// line and gives exactly one result beat: the key class of the reading, an
// event code and a click count. The reading is classified against seven
// band registers (first match of center, D, plus, minus; no match is open).
// A fresh D/plus or minus press gives a press event, such a key held until
// the hold counter equals long_press_ticks gives a long-press event on every
// further tick, and an open reading with the newest QUIET_LEN history
// entries open counts completed center clicks in the history and clears it
// when the count is nonzero. An open reading with a quiet history runs the
// click scan, which rotates the HISTORY_LEN-entry history through one pair
// comparator, one entry per cycle, and then passes to the done state;
// every other reading goes from acceptance straight to the done state. The
// done state loads the output register and frees the input. A stalled output
// register holds the finished item and keeps the input off for as long as
// it stalls. The input is not ready while an item is in work; a finished
// result sits in the output register, so the next beat can be taken while
// it waits. Configuration writes are always ready and take effect on the
// next accepted beat; write them only while idle.
`default_nettype none

module ladder_button_click_decoder #(
  parameter int unsigned HISTORY_LEN = ldbc_pkg::HISTORY_LEN_DEF,
  parameter int unsigned QUIET_LEN   = ldbc_pkg::QUIET_LEN_DEF,
  parameter int unsigned SAMPLE_BITS = ldbc_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write channel
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [ldbc_pkg::INDEX_W-1:0]  cfg_index_i,
  input  wire logic [ldbc_pkg::THR_W-1:0]    cfg_data_i,
  // sample channel
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [SAMPLE_BITS-1:0]        adc_sample_i,
  // result channel
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [ldbc_pkg::CLASS_W-1:0]       key_class_o,
  output logic [ldbc_pkg::EVENT_W-1:0]       event_code_o,
  output logic [ldbc_pkg::CLICK_W-1:0]       click_count_o
);
  import ldbc_pkg::*;

  localparam int unsigned CNT_W = (HISTORY_LEN > 1) ? $clog2(HISTORY_LEN) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(HISTORY_LEN - 1);
  localparam logic [CNT_W-1:0] SCAN_PAIRS = CNT_W'(HISTORY_LEN - QUIET_LEN);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  // configuration registers
  bands_t             bands_q;
  logic [TICKS_W-1:0] long_ticks_q;

  // sequencer and item state
  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q;
  logic [CLASS_W-1:0] class_q;
  logic [EVENT_W-1:0] ev_q;
  logic [CLICK_W-1:0] clicks_q;
  logic               fallen_q;
  logic [TICKS_W-1:0] hold_q;
  logic [CLASS_W-1:0] hist_q [HISTORY_LEN];

  logic [CLASS_W-1:0] cls;
  logic               in_fire, out_free, leave_done, quiet;
  logic [EVENT_W-1:0] ev_d;
  logic [TICKS_W-1:0] hold_d;
  logic [TICKS_W-1:0] hold_inc;
  logic [CLASS_W-1:0] tap_newer, tap_older;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bands_q.center_below <= RST_CENTER_BELOW;
      bands_q.d_from       <= RST_D_FROM;
      bands_q.d_below      <= RST_D_BELOW;
      bands_q.plus_from    <= RST_PLUS_FROM;
      bands_q.plus_below   <= RST_PLUS_BELOW;
      bands_q.minus_from   <= RST_MINUS_FROM;
      bands_q.minus_below  <= RST_MINUS_BELOW;
      long_ticks_q         <= RST_LONG_TICKS;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_CENTER_BELOW: bands_q.center_below <= cfg_data_i;
        REG_D_FROM:       bands_q.d_from       <= cfg_data_i;
        REG_D_BELOW:      bands_q.d_below      <= cfg_data_i;
        REG_PLUS_FROM:    bands_q.plus_from    <= cfg_data_i;
        REG_PLUS_BELOW:   bands_q.plus_below   <= cfg_data_i;
        REG_MINUS_FROM:   bands_q.minus_from   <= cfg_data_i;
        REG_MINUS_BELOW:  bands_q.minus_below  <= cfg_data_i;
        REG_LONG_TICKS:   long_ticks_q         <= cfg_data_i[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  ldbc_classify #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_classify (
    .sample_i    (adc_sample_i),
    .bands_i     (bands_q),
    .key_class_o (cls)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_o || out_ready_i;
  assign leave_done = (state_q == ST_DONE) && out_free;

  // newest QUIET_LEN entries must all be open before clicks are counted
  always_comb begin
    quiet = 1'b1;
    for (int k = 0; k < QUIET_LEN; k++) begin
      if (hist_q[k] != KEY_OPEN) quiet = 1'b0;
    end
  end

  // hold counter saturates
  assign hold_inc = (hold_q == HOLD_MAX) ? hold_q : hold_q + 8'd1;

  // press, long press and hold rules for the accepted sample
  always_comb begin
    ev_d   = EV_NONE;
    hold_d = hold_q;
    if (cls == KEY_OPEN) begin
      hold_d = '0;
    end else if (hist_q[0] == KEY_OPEN) begin
      if (cls == KEY_D || cls == KEY_PLUS) begin
        ev_d = EV_PRESS_UP;
      end else if (cls == KEY_MINUS) begin
        ev_d = EV_PRESS_DN;
      end
    end else if (hold_q == long_ticks_q) begin
      // long press fires again each tick since the count stays put
      if (cls == KEY_CENTER) begin
        hold_d = hold_inc;
      end else if (cls == KEY_D || cls == KEY_PLUS) begin
        ev_d = EV_LONG_UP;
      end else if (cls == KEY_MINUS) begin
        ev_d = EV_LONG_DN;
      end
    end else if (cls == hist_q[0]) begin
      hold_d = hold_inc;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = (cls == KEY_OPEN && quiet) ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (cnt_q == CNT_LAST) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // the scan rotates the history toward entry 0; these two taps see each
  // adjacent pair in turn, a full turn restores the original order
  assign tap_newer = hist_q[QUIET_LEN-1];
  assign tap_older = hist_q[QUIET_LEN];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      hold_q   <= '0;
      fallen_q <= 1'b0;
      clicks_q <= '0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        cnt_q    <= '0;
        hold_q   <= hold_d;
        fallen_q <= 1'b0;
        clicks_q <= '0;
      end else if (state_q == ST_SCAN) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q < SCAN_PAIRS) begin
          // center->open rising edge first (newest), then the open->center falling edge
          if (!fallen_q && tap_newer == KEY_OPEN && tap_older == KEY_CENTER) begin
            fallen_q <= 1'b1;
          end else if (fallen_q && tap_newer == KEY_CENTER && tap_older == KEY_OPEN) begin
            fallen_q <= 1'b0;
            if (clicks_q != CLICK_MAX) clicks_q <= clicks_q + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      class_q <= cls;
      ev_q    <= ev_d;
    end
  end

  // key history: rotate during the scan, shift in the class at the end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < HISTORY_LEN; k++) hist_q[k] <= KEY_OPEN;
    end else if (state_q == ST_SCAN) begin
      for (int k = 0; k < HISTORY_LEN - 1; k++) hist_q[k] <= hist_q[k+1];
      hist_q[HISTORY_LEN-1] <= hist_q[0];
    end else if (leave_done) begin
      if (clicks_q != '0) begin
        // counted clicks wipe the history; the new class is open anyway
        for (int k = 0; k < HISTORY_LEN; k++) hist_q[k] <= KEY_OPEN;
      end else begin
        for (int k = HISTORY_LEN - 1; k > 0; k--) hist_q[k] <= hist_q[k-1];
        hist_q[0] <= class_q;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (leave_done) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (leave_done) begin
      key_class_o   <= class_q;
      event_code_o  <= (clicks_q != '0) ? EV_CLICKS : ev_q;
      click_count_o <= clicks_q;
    end
  end

  // a click count only travels with a clicks event
  a_clicks_with_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_code_o != EV_CLICKS) |-> click_count_o == '0)
    else $error("click count without clicks event");

  // clicks are only reported on an open reading
  a_clicks_on_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_code_o == EV_CLICKS) |-> key_class_o == KEY_OPEN)
    else $error("clicks event on a pressed key");

  // the scan only runs for an open reading
  a_scan_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> class_q == KEY_OPEN)
    else $error("history scan for a pressed key");

  // the hold counter drops to zero only on an open reading
  a_hold_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hold_q != '0) ##1 (hold_q == '0) |-> class_q == KEY_OPEN)
    else $error("hold counter cleared while a key is held");

endmodule

`default_nettype wire

[hdl/ldbc_classify.sv]
// band classifier: maps one ladder sample to a key class
`default_nettype none

module ldbc_classify #(
  parameter int unsigned SAMPLE_BITS = ldbc_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic [SAMPLE_BITS-1:0]       sample_i,
  input  wire ldbc_pkg::bands_t             bands_i,
  output logic [ldbc_pkg::CLASS_W-1:0]      key_class_o
);
  import ldbc_pkg::*;

  localparam int unsigned CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

  logic [CMP_W-1:0] s_ext;

  function automatic logic [CMP_W-1:0] ext(input logic [THR_W-1:0] v);
    ext = CMP_W'(v);
  endfunction

  assign s_ext = CMP_W'(sample_i);

  // first matching band wins: center, D, plus, minus
  always_comb begin
    if (s_ext < ext(bands_i.center_below)) begin
      key_class_o = KEY_CENTER;
    end else if (s_ext >= ext(bands_i.d_from) && s_ext < ext(bands_i.d_below)) begin
      key_class_o = KEY_D;
    end else if (s_ext >= ext(bands_i.plus_from) && s_ext < ext(bands_i.plus_below)) begin
      key_class_o = KEY_PLUS;
    end else if (s_ext >= ext(bands_i.minus_from) && s_ext < ext(bands_i.minus_below)) begin
      key_class_o = KEY_MINUS;
    end else begin
      key_class_o = KEY_OPEN;
    end
  end

endmodule

`default_nettype wire

[dv/ladder_button_click_decoder_checker.sv]
// scoreboard for the ladder button decoder: predicts every result beat and compares it
module ladder_button_click_decoder_checker
  import ldbc_pkg::*;
#(
  parameter int unsigned HIST_DEPTH  = HISTORY_LEN_DEF,
  parameter int unsigned QUIET_DEPTH = QUIET_LEN_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic [INDEX_W-1:0]         cfg_index_i,
  input  logic [THR_W-1:0]           cfg_data_i,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic [SAMPLE_BITS_DEF-1:0] adc_sample_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic [CLASS_W-1:0]         key_class_i,
  input  logic [EVENT_W-1:0]         event_code_i,
  input  logic [CLICK_W-1:0]         click_count_i,
  output int                         mismatch_count_o,
  output int                         pending_o,
  output int                         results_o,
  output int                         click_events_o,
  output int                         press_events_o,
  output int                         long_events_o
);

  typedef struct packed {
    logic [CLASS_W-1:0] key_class;
    logic [EVENT_W-1:0] event_code;
    logic [CLICK_W-1:0] click_count;
  } tick_result_t;

  bands_t             bands;
  logic [TICKS_W-1:0] long_ticks;
  logic [CLASS_W-1:0] key_hist [HIST_DEPTH];
  logic [TICKS_W-1:0] hold_cnt;
  tick_result_t       expected_q [$];

  initial begin
    mismatch_count_o = 0;
    pending_o        = 0;
    results_o        = 0;
    click_events_o   = 0;
    press_events_o   = 0;
    long_events_o    = 0;
  end

  function automatic logic [CLASS_W-1:0] classify_sample(input logic [THR_W-1:0] s);
    if (s < bands.center_below) return KEY_CENTER;
    if (s >= bands.d_from && s < bands.d_below) return KEY_D;
    if (s >= bands.plus_from && s < bands.plus_below) return KEY_PLUS;
    if (s >= bands.minus_from && s < bands.minus_below) return KEY_MINUS;
    return KEY_OPEN;
  endfunction

  // completed center clicks, newest rising edge first; clears history on a hit
  function automatic logic [CLICK_W-1:0] scan_clicks();
    logic [CLICK_W-1:0] n;
    logic               fallen;
    n = '0;
    fallen = 1'b0;
    for (int i = 0; i < QUIET_DEPTH; i++) begin
      if (key_hist[i] != KEY_OPEN) return '0;
    end
    for (int i = QUIET_DEPTH; i < HIST_DEPTH; i++) begin
      if (!fallen && key_hist[i-1] == KEY_OPEN && key_hist[i] == KEY_CENTER) begin
        fallen = 1'b1;
      end else if (fallen && key_hist[i-1] == KEY_CENTER && key_hist[i] == KEY_OPEN) begin
        if (n != CLICK_MAX) n++;
        fallen = 1'b0;
      end
    end
    if (n != '0) begin
      for (int i = 0; i < HIST_DEPTH; i++) key_hist[i] = KEY_OPEN;
    end
    return n;
  endfunction

  function automatic tick_result_t decode_tick(input logic [THR_W-1:0] s);
    tick_result_t r;
    r.key_class   = classify_sample(s);
    r.event_code  = EV_NONE;
    r.click_count = '0;
    if (r.key_class == KEY_OPEN) begin
      hold_cnt = '0;
      r.click_count = scan_clicks();
      if (r.click_count != '0) r.event_code = EV_CLICKS;
    end else if (key_hist[0] == KEY_OPEN) begin
      if (r.key_class == KEY_MINUS) r.event_code = EV_PRESS_DN;
      else if (r.key_class != KEY_CENTER) r.event_code = EV_PRESS_UP;
    end else if (hold_cnt == long_ticks) begin
      if (r.key_class == KEY_CENTER) begin
        if (hold_cnt != HOLD_MAX) hold_cnt++;
      end else if (r.key_class == KEY_MINUS) begin
        r.event_code = EV_LONG_DN;
      end else begin
        r.event_code = EV_LONG_UP;
      end
    end else if (r.key_class == key_hist[0] && hold_cnt != HOLD_MAX) begin
      hold_cnt++;
    end
    for (int i = HIST_DEPTH - 1; i > 0; i--) key_hist[i] = key_hist[i-1];
    key_hist[0] = r.key_class;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    tick_result_t want;
    tick_result_t got;
    if (!rst_ni) begin
      bands.center_below = RST_CENTER_BELOW;
      bands.d_from       = RST_D_FROM;
      bands.d_below      = RST_D_BELOW;
      bands.plus_from    = RST_PLUS_FROM;
      bands.plus_below   = RST_PLUS_BELOW;
      bands.minus_from   = RST_MINUS_FROM;
      bands.minus_below  = RST_MINUS_BELOW;
      long_ticks         = RST_LONG_TICKS;
      hold_cnt           = '0;
      for (int i = 0; i < HIST_DEPTH; i++) key_hist[i] = KEY_OPEN;
      expected_q.delete();
      pending_o = 0;
    end else begin
      // compare first so a beat can never match an expectation pushed at this edge
      if (out_valid_i && out_ready_i) begin
        got = {key_class_i, event_code_i, click_count_i};
        if (expected_q.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10)
            $display("unexpected result beat: class %0d event %0d clicks %0d",
                     got.key_class, got.event_code, got.click_count);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            mismatch_count_o++;
            if (mismatch_count_o <= 10)
              $display("result %0d: expected class %0d event %0d clicks %0d, got %0d %0d %0d",
                       results_o, want.key_class, want.event_code, want.click_count,
                       got.key_class, got.event_code, got.click_count);
          end
          case (want.event_code)
            EV_CLICKS:                click_events_o++;
            EV_PRESS_UP, EV_PRESS_DN: press_events_o++;
            EV_LONG_UP, EV_LONG_DN:   long_events_o++;
            default: ;
          endcase
          results_o++;
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_CENTER_BELOW: bands.center_below = cfg_data_i;
          REG_D_FROM:       bands.d_from       = cfg_data_i;
          REG_D_BELOW:      bands.d_below      = cfg_data_i;
          REG_PLUS_FROM:    bands.plus_from    = cfg_data_i;
          REG_PLUS_BELOW:   bands.plus_below   = cfg_data_i;
          REG_MINUS_FROM:   bands.minus_from   = cfg_data_i;
          REG_MINUS_BELOW:  bands.minus_below  = cfg_data_i;
          REG_LONG_TICKS:   long_ticks         = cfg_data_i[TICKS_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) expected_q.push_back(decode_tick(adc_sample_i));
      pending_o = expected_q.size();
    end
  end

endmodule

[dv/ladder_button_click_decoder_tb.sv]
// testbench top for the ladder button decoder: stimulus, idling patterns and verdict
module ladder_button_click_decoder_tb;
  import ldbc_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int TIMEOUT_CYCLES = 1_000_000;
  localparam logic [THR_W-1:0] SAMPLE_MAX = {THR_W{1'b1}};

  // which side of the handshake idles during a phase
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  logic [INDEX_W-1:0]         cfg_index_i;
  logic [THR_W-1:0]           cfg_data_i;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic [SAMPLE_BITS_DEF-1:0] adc_sample_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic [CLASS_W-1:0]         key_class_o;
  logic [EVENT_W-1:0]         event_code_o;
  logic [CLICK_W-1:0]         click_count_o;

  int mismatch_count;
  int pending;
  int results;
  int click_events;
  int press_events;
  int long_events;

  // stimulus bookkeeping
  bands_t             cur_bands;
  logic [TICKS_W-1:0] cur_long;
  int                 send_idle_pct;
  int                 recv_stall_pct;
  int                 ready_hold_req;
  int                 samples_sent;
  int                 settings_used;

  ladder_button_click_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .adc_sample_i  (adc_sample_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .key_class_o   (key_class_o),
    .event_code_o  (event_code_o),
    .click_count_o (click_count_o)
  );

  // watches all three channels and keeps the expected result stream
  ladder_button_click_decoder_checker u_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .adc_sample_i     (adc_sample_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .key_class_i      (key_class_o),
    .event_code_i     (event_code_o),
    .click_count_i    (click_count_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending),
    .results_o        (results),
    .click_events_o   (click_events),
    .press_events_o   (press_events),
    .long_events_o    (long_events)
  );

  initial clk_i = 1'b0;
  always #CLK_HALF clk_i = ~clk_i;

  // hard stop in case a handshake never completes
  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("timeout after %0d cycles, %0d results still outstanding", TIMEOUT_CYCLES, pending);
    $display("Some tests failed");
    $finish;
  end

  // result side: random stalls, plus a long hold-off when one is requested;
  // the hold-off is counted here so the sender keeps offering beats meanwhile
  initial begin : receiver
    int hold_left;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (ready_hold_req > 0) begin
        hold_left      = ready_hold_req;
        ready_hold_req = 0;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic bands_t make_bands(input logic [THR_W-1:0] c_below,
                                        input logic [THR_W-1:0] d_lo, input logic [THR_W-1:0] d_hi,
                                        input logic [THR_W-1:0] p_lo, input logic [THR_W-1:0] p_hi,
                                        input logic [THR_W-1:0] m_lo, input logic [THR_W-1:0] m_hi);
    bands_t b;
    b.center_below = c_below;
    b.d_from       = d_lo;
    b.d_below      = d_hi;
    b.plus_from    = p_lo;
    b.plus_below   = p_hi;
    b.minus_from   = m_lo;
    b.minus_below  = m_hi;
    return b;
  endfunction

  // anything at or above every upper bound matches no band, so full scale is always open
  function automatic logic [THR_W-1:0] open_sample();
    logic [THR_W-1:0] floor_v;
    floor_v = cur_bands.center_below;
    if (cur_bands.d_below > floor_v) floor_v = cur_bands.d_below;
    if (cur_bands.plus_below > floor_v) floor_v = cur_bands.plus_below;
    if (cur_bands.minus_below > floor_v) floor_v = cur_bands.minus_below;
    return THR_W'($urandom_range(floor_v, SAMPLE_MAX));
  endfunction

  // a reading inside the band of a key; an empty band falls back to a random reading,
  // overlapping bands may well classify it as an earlier key
  function automatic logic [THR_W-1:0] band_sample(input logic [CLASS_W-1:0] cls);
    logic [THR_W-1:0] lo;
    logic [THR_W-1:0] hi;
    lo = '0;
    hi = '0;
    case (cls)
      KEY_CENTER: hi = cur_bands.center_below;
      KEY_D: begin
        lo = cur_bands.d_from;
        hi = cur_bands.d_below;
      end
      KEY_PLUS: begin
        lo = cur_bands.plus_from;
        hi = cur_bands.plus_below;
      end
      KEY_MINUS: begin
        lo = cur_bands.minus_from;
        hi = cur_bands.minus_below;
      end
      default: return open_sample();
    endcase
    if (hi <= lo) return THR_W'($urandom_range(0, SAMPLE_MAX));
    return THR_W'($urandom_range(lo, hi - 1));
  endfunction

  // one beat on the sample channel; starts and ends at a falling edge, valid stays
  // high into the next call unless that call idles first
  task automatic send_sample(input logic [THR_W-1:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    adc_sample_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
    samples_sent++;
    @(negedge clk_i);
  endtask

  task automatic hold_key(input logic [CLASS_W-1:0] cls, input int ticks);
    repeat (ticks) send_sample(band_sample(cls));
  endtask

  // drop valid and wait until every expected result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // all eight registers, in index order, one beat each
  task automatic write_settings(input bands_t b, input logic [THR_W-1:0] ticks_word);
    logic [INDEX_W-1:0] regs [8];
    logic [THR_W-1:0]   vals [8];
    regs = '{REG_CENTER_BELOW, REG_D_FROM, REG_D_BELOW, REG_PLUS_FROM,
             REG_PLUS_BELOW, REG_MINUS_FROM, REG_MINUS_BELOW, REG_LONG_TICKS};
    vals = '{b.center_below, b.d_from, b.d_below, b.plus_from,
             b.plus_below, b.minus_from, b.minus_below, ticks_word};
    for (int i = 0; i < 8; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= regs[i];
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    cur_bands = b;
    cur_long  = ticks_word[TICKS_W-1:0];
    settings_used++;
  endtask

  // mostly well-formed key activity: click bursts, holds around the long-press
  // count, key changes while held; the rest is noise and unfinished clicks
  task automatic run_random(input int n_items);
    int                 start_cnt;
    int                 kind;
    logic [CLASS_W-1:0] key_a;
    logic [CLASS_W-1:0] key_b;
    start_cnt = samples_sent;
    while (samples_sent - start_cnt < n_items) begin
      kind  = $urandom_range(99);
      key_a = CLASS_W'($urandom_range(KEY_CENTER, KEY_MINUS));
      key_b = CLASS_W'($urandom_range(KEY_CENTER, KEY_MINUS));
      if (kind < 35) begin
        repeat ($urandom_range(1, 5)) begin
          hold_key(KEY_CENTER, $urandom_range(1, 3));
          hold_key(KEY_OPEN, $urandom_range(1, 3));
        end
        hold_key(KEY_OPEN, $urandom_range(2, 6));
      end else if (kind < 70) begin
        hold_key(key_a, $urandom_range(1, int'(cur_long) + 4));
        if ($urandom_range(99) < 30) hold_key(key_b, $urandom_range(1, 6));
        hold_key(KEY_OPEN, $urandom_range(1, 3));
      end else if (kind < 85) begin
        repeat ($urandom_range(1, 8)) send_sample(THR_W'($urandom_range(0, SAMPLE_MAX)));
      end else begin
        // click cut short by another key before the line goes quiet
        hold_key(KEY_CENTER, $urandom_range(1, 2));
        hold_key(KEY_OPEN, $urandom_range(1, 2));
        hold_key(key_a, $urandom_range(1, 3));
        hold_key(KEY_OPEN, $urandom_range(3, 5));
      end
    end
  endtask

  task automatic run_phase(input bands_t b, input logic [THR_W-1:0] ticks_word,
                           input idle_mode_e mode, input int n_items, input bit squeeze);
    drain();
    write_settings(b, ticks_word);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct  = 64;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct  = 0;
        recv_stall_pct = 64;
      end
      default: begin
        send_idle_pct  = 38;
        recv_stall_pct = 38;
      end
    endcase
    // long output stall while the sender keeps going, so the input backs up
    if (squeeze) ready_hold_req = 300;
    run_random(n_items);
  endtask

  initial begin : stimulus
    logic [THR_W-1:0] directed [23];
    bands_t           dflt;
    bands_t           rnd;
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = REG_CENTER_BELOW;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    adc_sample_i   = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    ready_hold_req = 0;
    samples_sent   = 0;
    settings_used  = 1;
    dflt = make_bands(RST_CENTER_BELOW, RST_D_FROM, RST_D_BELOW, RST_PLUS_FROM,
                      RST_PLUS_BELOW, RST_MINUS_FROM, RST_MINUS_BELOW);
    cur_bands = dflt;
    cur_long  = RST_LONG_TICKS;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed at reset values: full-scale extremes, band edges, fresh presses,
    // then two center clicks closed by a quiet line
    directed = '{10'd0, 10'd1023, 10'd30, 10'd31, 10'd44, 10'd72, 10'd73, 10'd123,
                 10'd124, 10'd134, 10'd223, 10'd224, 10'd43, 10'd0, 10'd1023, 10'd15,
                 10'd512, 10'd512, 10'd512, 10'd512, 10'd512, 10'd682, 10'd341};
    foreach (directed[i]) send_sample(directed[i]);

    run_phase(dflt, THR_W'(RST_LONG_TICKS), IDLE_NONE, 80, 1'b0);
    // center held far past the long-press count drives the hold counter into saturation
    hold_key(KEY_CENTER, 270);
    hold_key(KEY_OPEN, 2);
    run_phase(dflt, 10'd1, IDLE_SENDER, 80, 1'b0);
    // a zero long-press count, with the unused upper data bits set
    run_phase(dflt, 10'h300, IDLE_RECEIVER, 70, 1'b1);
    // long-press count of 255 only fires once the counter is full
    run_phase(dflt, 10'h2ff, IDLE_BOTH, 60, 1'b0);
    hold_key(KEY_D, 260);
    hold_key(KEY_OPEN, 1);
    hold_key(KEY_MINUS, 258);
    hold_key(KEY_OPEN, 1);
    // overlapping bands: first match wins
    run_phase(make_bands(10'd100, 10'd50, 10'd200, 10'd150, 10'd300, 10'd0, 10'd1023),
              10'd3, IDLE_NONE, 70, 1'b0);
    // empty bands and no center band at all
    run_phase(make_bands(10'd0, 10'd500, 10'd500, 10'd600, 10'd400, 10'd700, 10'd1023),
              10'd2, IDLE_SENDER, 70, 1'b0);
    // every threshold at full scale: all but the top reading is center
    run_phase(make_bands(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX,
                         SAMPLE_MAX, SAMPLE_MAX), 10'd254, IDLE_RECEIVER, 60, 1'b0);
    // random ascending bands
    rnd.center_below = THR_W'($urandom_range(0, 60));
    rnd.d_from       = rnd.center_below + THR_W'($urandom_range(0, 120));
    rnd.d_below      = rnd.d_from + THR_W'($urandom_range(0, 120));
    rnd.plus_from    = rnd.d_below + THR_W'($urandom_range(0, 120));
    rnd.plus_below   = rnd.plus_from + THR_W'($urandom_range(0, 120));
    rnd.minus_from   = rnd.plus_below + THR_W'($urandom_range(0, 120));
    rnd.minus_below  = rnd.minus_from + THR_W'($urandom_range(0, 120));
    run_phase(rnd, THR_W'($urandom_range(1, 20)) | 10'h200, IDLE_BOTH, 90, 1'b0);
    // wide bands in the upper half of the range
    run_phase(make_bands(10'd512, 10'd512, 10'd700, 10'd700, 10'd900, 10'd900, 10'd1000),
              10'h105, IDLE_NONE, 90, 1'b0);

    drain();
    repeat (40) @(negedge clk_i);

    $display("ran %0d readings through %0d band settings, every idling mix and a long output stall",
             samples_sent, settings_used);
    $display("checked %0d results: %0d click counts, %0d presses, %0d long presses",
             results, click_events, press_events, long_events);
    if (mismatch_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/ldbc_pkg.sv
hdl/ldbc_classify.sv
hdl/ladder_button_click_decoder.sv
dv/ladder_button_click_decoder_checker.sv
dv/ladder_button_click_decoder_tb.sv
